// File: sv/wrsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// wrsi_pkg: shared constants for the windowed relative strength index
// Field widths, register map and fixed scale factors used by every module but the ring.
// ============================================================================
package wrsi_pkg;

   // Width of the close price field as it arrives on the request channel.
   localparam int PRICE_W = 32;

   // Width of the index value field and of the quotient built by the divider.
   localparam int OUT_W = 15;
   localparam int QUO_W = 15;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   // Full scale of the index: 100.0 with 8 fraction bits.
   localparam logic [OUT_W-1:0] FULL_SCALE = 15'd25600;

   // Configuration register map.
   localparam int CFG_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd14;

endpackage : wrsi_pkg
`default_nettype wire

// File: sv/wrsi_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// wrsi_ring: change history memory
// One write port and one registered read port over the ring of price changes.
// ============================================================================
module wrsi_ring #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 33
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : wrsi_ring
`default_nettype wire

// File: sv/wrsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// wrsi_div: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder per cycle and shifts one
// quotient bit out, so only one subtract and compare sits between registers.
// ============================================================================
module wrsi_div #(
   parameter int SUM_W = 38
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [SUM_W-1:0]           rem_init,
   input  wire logic [wrsi_pkg::QUO_W-1:0] low_bits,
   input  wire logic [SUM_W-1:0]           divisor,
   output logic                            done,
   output logic      [wrsi_pkg::QUO_W-1:0] quotient
);
   import wrsi_pkg::*;

   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     dig_ff, dig_in;
   logic [SUM_W-1:0]     dvs_ff, dvs_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SUM_W:0]       part;
   logic [SUM_W:0]       diff;
   logic                 ge;

   always_comb begin
      part    = {rem_ff, dig_ff[QUO_W-1]};
      diff    = part - {1'b0, dvs_ff};
      ge      = part >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dig_in  = dig_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         dig_in  = low_bits;
         dvs_in  = divisor;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder always stays below the divisor, so the
         // dropped top bit is zero after the restore.
         rem_in = ge ? diff[SUM_W-1:0] : part[SUM_W-1:0];
         dig_in = {dig_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dig_ff <= dig_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule : wrsi_div
`default_nettype wire

// File: sv/windowed_relative_strength_index.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// windowed_relative_strength_index: windowed RSI over a stream of prices
// Keeps the last window_length price changes and their gain and loss sums and
// returns 100 * gain / (gain + loss) in Q7.8 once the window is full.
// ============================================================================
// Each request carries one closing price; each request yields exactly one
// response. The first request after reset only records the price and returns
// an index of 0 with the valid flag clear. Later requests form a change
// against the previous price, push it into a ring memory, retire the change
// that falls out of the window, and update running gain and loss sums. Once
// window_length changes have been seen the flag is set and the index is
// 100 * gain / (gain + loss) rounded down, or 100.0 when the loss sum is zero;
// before that the index reads 0. Writing window_length restarts the window
// but keeps the previous price. A window length of zero acts as one, and a
// length above MAX_WINDOW acts as MAX_WINDOW. The block handles one request
// at a time: a full index passes through the ring read, the two sum updates,
// the two-step scaling by 100, the bit-serial divider that produces one
// quotient bit per cycle, and the hand-off to the response register before
// the next request is accepted. A request whose window is not yet full, or
// whose loss sum is zero, skips the scaling and the divider, and the very
// first request after reset goes straight to the hand-off. A new request is
// taken while the previous response still waits in the output register.
// ============================================================================
module windowed_relative_strength_index #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [wrsi_pkg::PRICE_W-1:0]         req_tdata,  // [31:0] close_price
   // Response channel.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [15:0]                          rsp_tdata,  // [14:0] index_value
   output logic                                      rsp_tuser,  // [0] index_valid
   // Configuration port.
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [wrsi_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [wrsi_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic      [wrsi_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                      csr_pready
);
   import wrsi_pkg::*;

   // Ring pointer, window length and sum widths all follow from the window
   // depth and the price width.
   localparam int PTR_W = $clog2(MAX_WINDOW);
   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W = LEN_W + 1;
   localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
   localparam int SUM_W = PRICE_BITS + PTR_W;
   localparam int SCL_W = SUM_W + 7;
   localparam int ENT_W = PRICE_BITS + 1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SUB  = 7'b0000010,
      ST_ADD  = 7'b0000100,
      ST_MUL1 = 7'b0001000,
      ST_MUL2 = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      wlen_ff, wlen_in;
   logic [PRICE_BITS-1:0] prev_ff, prev_in;
   logic                  have_prev_ff, have_prev_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [LEN_W-1:0]      seen_ff, seen_in;
   logic [SUM_W-1:0]      gain_ff, gain_in;
   logic [SUM_W-1:0]      loss_ff, loss_in;
   logic                  drop_ff, drop_in;
   logic [PRICE_BITS-1:0] mag_ff, mag_in;
   logic                  up_ff, up_in;
   logic [SCL_W-1:0]      scale_ff, scale_in;
   logic [SUM_W-1:0]      dvs_ff, dvs_in;
   logic [OUT_W-1:0]      res_value_ff, res_value_in;
   logic                  res_valid_ff, res_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                  rsp_flag_ff, rsp_flag_in;

   logic [PRICE_BITS+PRICE_W-1:0] price_ext;
   logic [PRICE_BITS-1:0]         price;
   logic [CMP_W-1:0]              wlen_ext;
   logic [LEN_W-1:0]              len;
   logic [IDX_W-1:0]              old_sum;
   logic [IDX_W-1:0]              old_wrap;
   logic [PTR_W-1:0]              old_idx;
   logic                          req_accept;
   logic                          csr_write;
   logic                          rsp_load;
   logic [SCL_W-1:0]              scaled;
   logic [ENT_W-1:0]              old_entry;
   logic                          ring_wr_en;
   logic                          div_start;
   logic                          div_done;
   logic [QUO_W-1:0]              div_quo;

   // Only the low PRICE_BITS bits of the price take part.
   assign price_ext = {{PRICE_BITS{1'b0}}, req_tdata};
   assign price     = price_ext[PRICE_BITS-1:0];

   // Effective window length: zero acts as one, large values saturate.
   always_comb begin
      wlen_ext = CMP_W'(wlen_ff);
      if (wlen_ff == '0) begin
         len = LEN_W'(1);
      end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = LEN_W'(wlen_ext);
      end
   end

   // Slot of the change that leaves the window: pointer minus length, modulo
   // the ring depth, which need not be a power of two.
   always_comb begin
      old_sum  = IDX_W'(ptr_ff) + IDX_W'(MAX_WINDOW) - IDX_W'(len);
      old_wrap = (old_sum >= IDX_W'(MAX_WINDOW)) ? old_sum - IDX_W'(MAX_WINDOW) : old_sum;
      old_idx  = old_wrap[PTR_W-1:0];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);
   assign scaled     = scale_ff + SCL_W'({gain_ff, 2'b00});
   assign ring_wr_en = (state_ff == ST_ADD);
   assign div_start  = (state_ff == ST_MUL2);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_WINDOW_LENGTH) begin
         csr_prdata = CSR_DATA_W'(wlen_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      ptr_in       = ptr_ff;
      seen_in      = seen_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      drop_in      = drop_ff;
      mag_in       = mag_ff;
      up_in        = up_ff;
      scale_in     = scale_ff;
      dvs_in       = dvs_ff;
      res_value_in = res_value_ff;
      res_valid_in = res_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               prev_in      = price;
               have_prev_in = 1'b1;
               if (!have_prev_ff) begin
                  res_value_in = '0;
                  res_valid_in = 1'b0;
                  state_in     = ST_FIN;
               end else begin
                  up_in    = price > prev_ff;
                  mag_in   = (price > prev_ff) ? price - prev_ff : prev_ff - price;
                  drop_in  = seen_ff >= len;
                  state_in = ST_SUB;
               end
            end
         end
         ST_SUB: begin
            // Retire the change that falls out of a full window.
            if (drop_ff) begin
               if (old_entry[ENT_W-1]) begin
                  gain_in = gain_ff - SUM_W'(old_entry[PRICE_BITS-1:0]);
               end else begin
                  loss_in = loss_ff - SUM_W'(old_entry[PRICE_BITS-1:0]);
               end
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (up_ff) begin
               gain_in = gain_ff + SUM_W'(mag_ff);
            end else begin
               loss_in = loss_ff + SUM_W'(mag_ff);
            end
            ptr_in = (ptr_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_ff + PTR_W'(1);
            if (seen_ff < LEN_W'(MAX_WINDOW)) begin
               seen_in = seen_ff + LEN_W'(1);
            end
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            res_valid_in = seen_ff >= len;
            if (seen_ff < len) begin
               res_value_in = '0;
               state_in     = ST_FIN;
            end else if (loss_ff == '0) begin
               res_value_in = FULL_SCALE;
               state_in     = ST_FIN;
            end else begin
               // 100 * gain is built as 64g + 32g, registered, plus 4g added at the divider start.
               scale_in = SCL_W'({gain_ff, 6'b000000}) + SCL_W'({gain_ff, 5'b00000});
               dvs_in   = gain_ff + loss_ff;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_value_in = div_quo;
               state_in     = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write restarts the window; the user must write it only while idle, as the block does not enforce it.
      if (csr_write && (csr_paddr[2] == REG_WINDOW_LENGTH)) begin
         wlen_in = csr_pwdata[CFG_W-1:0];
         ptr_in  = '0;
         seen_in = '0;
         gain_in = '0;
         loss_in = '0;
      end
   end

   // The response register frees the datapath while a response waits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_flag_in  = res_valid_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= WINDOW_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         ptr_ff       <= '0;
         seen_ff      <= '0;
         gain_ff      <= '0;
         loss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         ptr_ff       <= ptr_in;
         seen_ff      <= seen_in;
         gain_ff      <= gain_in;
         loss_ff      <= loss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_ff      <= drop_in;
      mag_ff       <= mag_in;
      up_ff        <= up_in;
      scale_ff     <= scale_in;
      dvs_ff       <= dvs_in;
      res_value_ff <= res_value_in;
      res_valid_ff <= res_valid_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   wrsi_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (ENT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ptr_ff),
      .wr_data ({up_ff, mag_ff}),
      .rd_en   (req_accept),
      .rd_addr (old_idx),
      .rd_data (old_entry)
   );

   // The top bits of 25600 * gain are already below the divisor, so only the
   // low fifteen dividend bits need to go through the divider.
   wrsi_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (scaled[SCL_W-1:7]),
      .low_bits ({scaled[6:0], 8'h00}),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_flag_ff;

`ifndef SYNTH
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(MAX_WINDOW - 1))
      else $error("ring pointer beyond the ring depth");

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= LEN_W'(MAX_WINDOW))
      else $error("change count beyond the ring depth");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_flag_ff) |-> (rsp_value_ff == '0))
      else $error("index not zero while the window is not full");

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff <= FULL_SCALE))
      else $error("index above full scale");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide phase");
`endif

endmodule : windowed_relative_strength_index
`default_nettype wire

// File: tb/rsi_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rsi_checker: response predictor and checker for the windowed RSI block
// Watches the request, response and register channels, keeps its own copy of
// the price window, and compares every response with the predicted index.
// ============================================================================
module rsi_checker #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [wrsi_pkg::PRICE_W-1:0]    req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [15:0]                     rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wrsi_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wrsi_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [wrsi_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              outstanding,
   output int                              mismatches,
   output int                              indices_checked,
   output int                              valid_indices
);
   import wrsi_pkg::*;

   localparam int SUM_W = PRICE_W + $clog2(MAX_WINDOW);
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = CSR_ADDR_W'({REG_WINDOW_LENGTH, 2'b00});

   typedef struct packed {
      logic [OUT_W-1:0] index_value;
      logic             index_valid;
   } index_result_type;

   index_result_type pending_index_q[$];

   logic [CFG_W-1:0]   window_len;
   logic [PRICE_W-1:0] last_price;
   logic               have_last;
   logic [PRICE_W-1:0] ring_mag [MAX_WINDOW];
   logic               ring_up  [MAX_WINDOW];
   int unsigned        ring_ptr;
   int unsigned        changes_seen;
   logic [SUM_W-1:0]   gain_sum;
   logic [SUM_W-1:0]   loss_sum;
   int                 errors;
   int                 checked;
   int                 valids;

   function automatic void restart_window();
      ring_ptr     = 0;
      changes_seen = 0;
      gain_sum     = '0;
      loss_sum     = '0;
   endfunction

   // Advance the window by one price and return the index it produces.
   function automatic index_result_type next_index(input logic [PRICE_W-1:0] price);
      index_result_type r;
      int unsigned      span;
      int unsigned      oldest;
      logic             up;
      logic [PRICE_W-1:0] mag;
      logic [63:0]      num;
      logic [63:0]      den;
      r.index_value = '0;
      r.index_valid = 1'b0;
      if (window_len == 0) span = 1;
      else if (window_len > MAX_WINDOW) span = MAX_WINDOW;
      else span = 32'(window_len);
      if (!have_last) begin
         last_price = price;
         have_last  = 1'b1;
         return r;
      end
      up  = price > last_price;
      mag = up ? price - last_price : last_price - price;
      if (changes_seen >= span) begin
         oldest = (ring_ptr + MAX_WINDOW - span) % MAX_WINDOW;
         if (ring_up[oldest]) gain_sum -= SUM_W'(ring_mag[oldest]);
         else loss_sum -= SUM_W'(ring_mag[oldest]);
      end
      ring_mag[ring_ptr] = mag;
      ring_up[ring_ptr]  = up;
      if (up) gain_sum += SUM_W'(mag);
      else loss_sum += SUM_W'(mag);
      ring_ptr = (ring_ptr + 1) % MAX_WINDOW;
      if (changes_seen < MAX_WINDOW) changes_seen++;
      last_price = price;
      if (changes_seen >= span) begin
         r.index_valid = 1'b1;
         if (loss_sum == 0) begin
            r.index_value = FULL_SCALE;
         end else begin
            num = 64'(gain_sum) * 64'(FULL_SCALE);
            den = 64'(gain_sum) + 64'(loss_sum);
            r.index_value = OUT_W'(num / den);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      index_result_type want;
      if (reset) begin
         pending_index_q.delete();
         window_len = WINDOW_RESET;
         last_price = '0;
         have_last  = 1'b0;
         restart_window();
         errors  = 0;
         checked = 0;
         valids  = 0;
      end else begin
         // A response can never belong to a request taken at the same edge,
         // so responses are matched before new requests are queued.
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (rsp_tdata[15:OUT_W] != '0) begin
               errors++;
               $error("rsp_tdata padding: expected 0, actual %0d", rsp_tdata[15:OUT_W]);
            end
            if (pending_index_q.size() == 0) begin
               errors++;
               $error("response without a pending request: index_value %0d index_valid %0d",
                      rsp_tdata[OUT_W-1:0], rsp_tuser);
            end else begin
               want = pending_index_q.pop_front();
               if (want.index_valid) valids++;
               if (rsp_tdata[OUT_W-1:0] !== want.index_value) begin
                  errors++;
                  $error("index_value: expected %0d, actual %0d",
                         want.index_value, rsp_tdata[OUT_W-1:0]);
               end
               if (rsp_tuser !== want.index_valid) begin
                  errors++;
                  $error("index_valid: expected %0d, actual %0d", want.index_valid, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_index_q = {pending_index_q, next_index(req_tdata)};
         end
         if (csr_psel && csr_penable && csr_pready && csr_paddr == WINDOW_ADDR) begin
            if (csr_pwrite) begin
               window_len = csr_pwdata[CFG_W-1:0];
               restart_window();
            end else if (csr_prdata !== CSR_DATA_W'(window_len)) begin
               errors++;
               $error("window_length: expected %0d, actual %0d", window_len, csr_prdata);
            end
         end
      end
      outstanding     <= pending_index_q.size();
      mismatches      <= errors;
      indices_checked <= checked;
      valid_indices   <= valids;
   end

endmodule

// File: tb/windowed_relative_strength_index_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// windowed_relative_strength_index_tb: regression for the windowed RSI block
// Drives price requests through a directed warm-up and randomized price walks
// over several window lengths, with random stalls on both channels, and
// reports the checker's verdict.
// ============================================================================
module windowed_relative_strength_index_tb;
   import wrsi_pkg::*;

   localparam int MAX_WINDOW  = 64;
   localparam int HALF_PERIOD = 5;
   // Random requests per window setting; ten settings give the bulk of the run.
   localparam int PHASE_ITEMS = 93;
   // A full index passes through the bit-serial divider, and response stalls are
   // short, so this limit is many times the slowest quiet gap.
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last response, comfortably above the latency.
   localparam int TAIL_CYCLES = 40;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = CSR_ADDR_W'({REG_WINDOW_LENGTH, 2'b00});
   // Register index one: nothing is mapped there, so writes must be ignored.
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);
   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

   typedef enum int {TREND_WALK, TREND_RISE, TREND_FALL, TREND_FLAT, TREND_NOISE} trend_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [PRICE_W-1:0]    req_tdata   = '0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [15:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // When steady is set, neither side inserts idle cycles.
   logic steady = 1'b0;
   int   outstanding;
   int   mismatches;
   int   indices_checked;
   int   valid_indices;
   int   quiet_cycles     = 0;
   int   requests_sent    = 0;
   int   settings_applied = 0;

   always #(HALF_PERIOD) clock = ~clock;

   windowed_relative_strength_index #(
      .MAX_WINDOW(MAX_WINDOW),
      .PRICE_BITS(PRICE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] close_price
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [14:0] index_value, [15] zero
      .rsp_tuser  (rsp_tuser),    // [0] index_valid
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   rsi_checker #(.MAX_WINDOW(MAX_WINDOW)) index_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .outstanding    (outstanding),
      .mismatches     (mismatches),
      .indices_checked(indices_checked),
      .valid_indices  (valid_indices)
   );

   // The response side stalls at random with a chance of about 16 percent, except
   // while the steady stretch runs.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 16);
   end

   // Watchdog: any handshake on any channel restarts the count of quiet
   // cycles. A hung block ends the run here.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d responses still pending.",
                  quiet_cycles, outstanding);
         $display("windowed_relative_strength_index regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one price and return at the edge where it is taken. The valid stays
   // high on return so that back-to-back requests never drop it in between;
   // idle cycles before the offer are where it goes low.
   task automatic offer_price(input logic [PRICE_W-1:0] price);
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= price;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // Stop sending and wait until every request has had its response. The
   // first edge lets the checker count the request taken last.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One register transfer: a setup cycle, then the access cycle held until
   // pready. A spare cycle at the end keeps psel from being lowered and raised
   // in the same step when two transfers follow each other.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change the window length once the block is idle. The upper data bits are
   // random because only the low seven bits belong to the register. A write to
   // the unmapped address follows, and a read-back confirms that it changed
   // nothing.
   task automatic set_window(input logic [CFG_W-1:0] len);
      logic [CSR_DATA_W-1:0] data;
      drain_responses();
      data = $urandom();
      data[CFG_W-1:0] = len;
      csr_access(1'b1, WINDOW_ADDR, data);
      csr_access(1'b1, SPARE_ADDR, $urandom());
      csr_access(1'b0, WINDOW_ADDR, '0);
      settings_applied++;
   endtask

   initial begin
      // Reset window of 14: the first price only seeds the window, then zero
      // changes, full-range swings and small steps fill fourteen changes.
      logic [PRICE_W-1:0] warmup_prices [15] = '{
         32'h0, 32'h0, PRICE_MAX, 32'h0, PRICE_MAX, 32'h0, 32'd5, 32'd5,
         32'd6, 32'd6, 32'd7, 32'd7, 32'd8, 32'd8, PRICE_MAX};
      // Window of one: a zero change (an all-zero window reads full scale), a
      // loss of one, a gain, and full-range drops and rises.
      logic [PRICE_W-1:0] single_prices [6] = '{
         PRICE_MAX, PRICE_MAX - 1, PRICE_MAX, 32'h0, PRICE_MAX, 32'h0};
      // Window of two: pure gains, an even split, and a split that rounds down.
      logic [PRICE_W-1:0] pair_prices [4] = '{32'd10, 32'd20, 32'd10, 32'd13};
      logic [CFG_W-1:0]   window_plan [10] = '{7'd2, 7'd0, 7'd64, 7'd127, 7'd3,
                                               7'd14, 7'd65, 7'd1, 7'd1, 7'd40};
      logic [PRICE_W-1:0] walk_price;
      logic [PRICE_W-1:0] price;
      logic [PRICE_W-1:0] step;
      trend_type          trend;
      int                 trend_left;
      int                 p;
      int                 i;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (warmup_prices[k]) offer_price(warmup_prices[k]);
      set_window(7'd1);
      foreach (single_prices[k]) offer_price(single_prices[k]);
      set_window(7'd2);
      foreach (pair_prices[k]) offer_price(pair_prices[k]);

      // Random part. Each setting runs a price series built from short runs
      // of walks, clean up or down trends (which reach full scale and zero),
      // flat stretches and raw noise. Zero acts as one and values above the
      // ring depth saturate, so both show up in the plan; one slot is random.
      window_plan[7] = CFG_W'($urandom_range(1, 127));
      walk_price = 32'd13;
      trend      = TREND_WALK;
      trend_left = 0;
      for (p = 0; p < 10; p++) begin
         set_window(window_plan[p]);
         // The ring-depth window runs as one long stretch without idling.
         steady <= (p == 2);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // Once, halfway through a phase, hold the sender until every
            // response has come back.
            if (p == 0 && i == PHASE_ITEMS / 2) drain_responses();
            if (trend_left == 0) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: trend = TREND_WALK;
                  4, 5:       trend = TREND_RISE;
                  6, 7:       trend = TREND_FALL;
                  8:          trend = TREND_FLAT;
                  default:    trend = TREND_NOISE;
               endcase
               trend_left = $urandom_range(1, 24);
            end
            trend_left--;
            // Step sizes spread over every magnitude from one bit to full width.
            step = $urandom() >> $urandom_range(0, PRICE_W - 1);
            case (trend)
               TREND_RISE:  price = (walk_price > PRICE_MAX - step) ? PRICE_MAX
                                                                    : walk_price + step;
               TREND_FALL:  price = (walk_price < step) ? '0 : walk_price - step;
               TREND_FLAT:  price = walk_price;
               TREND_NOISE: price = ($urandom_range(0, 3) == 0)
                                    ? {PRICE_W{$urandom_range(0, 1) == 1}} : $urandom();
               default:     price = $urandom_range(0, 1) ? walk_price + step
                                                         : walk_price - step;
            endcase
            offer_price(price);
            walk_price = price;
         end
      end
      steady <= 1'b0;

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d price requests over the reset window and %0d written window lengths.",
               requests_sent, settings_applied);
      $display("Compared %0d responses, %0d of them over a full window.",
               indices_checked, valid_indices);
      if (mismatches == 0 && outstanding == 0) begin
         $display("windowed_relative_strength_index regression: pass");
      end else begin
         $display("windowed_relative_strength_index regression: fail");
      end
      $finish;
   end

endmodule
